FILE: design/ffa_pkg.sv
package ffa_pkg;

	// Default geometry of the heap.
	localparam int HEAP_UNITS_DEF = 1024;
	localparam int UNIT_BYTES_DEF = 16;

	// Widths fixed by the interface.
	localparam int ADDR_W  = 32;
	localparam int REQ_W   = 16;
	localparam int LIMIT_W = 17;
	localparam int STAT_W  = 3;
	localparam int NEED_W  = 17;

	localparam logic [LIMIT_W-1:0] BIG_LIMIT_RST = 17'd16384;

	// Configuration register indexes.
	localparam logic CFG_HEAP_BASE = 1'b0;
	localparam logic CFG_BIG_LIMIT = 1'b1;

	// Request modes.
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	// Result status codes.
	localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
	localparam logic [STAT_W-1:0] ST_ZERO    = 3'd1;
	localparam logic [STAT_W-1:0] ST_BIG     = 3'd2;
	localparam logic [STAT_W-1:0] ST_OOM     = 3'd3;
	localparam logic [STAT_W-1:0] ST_IGNORED = 3'd4;

	// Datapath operations issued by the controller.
	typedef enum logic [4:0] {
		OP_IDLE,
		OP_LOAD,
		OP_NEED,
		OP_RD_CUR,
		OP_ADV,
		OP_TAKE,
		OP_RD_NX,
		OP_WR_NX,
		OP_WR_TAKE,
		OP_APPEND,
		OP_FCAP,
		OP_RD_P,
		OP_MRG_P,
		OP_MRG_N,
		OP_WR_FREE,
		OP_RESULT
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [STAT_W-1:0] code;
	} cmd_t;

	typedef struct packed {
		logic mode;
		logic req_zero;
		logic req_big;
		logic cur_ge_top;
		logic bs_zero;
		logic fit;
		logic split;
		logic nx_lt_top;
		logic match;
		logic rd_free;
		logic b_zero;
		logic oom;
	} sts_t;

endpackage

FILE: design/ffa_ram.sv
module ffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/ffa_dp.sv
module ffa_dp #(
	parameter int HEAP_UNITS = ffa_pkg::HEAP_UNITS_DEF,
	parameter int UNIT_BYTES = ffa_pkg::UNIT_BYTES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [ffa_pkg::ADDR_W-1:0]   cfg_data,
	input  logic                         mode,
	input  logic [ffa_pkg::REQ_W-1:0]    req_size,
	input  logic [ffa_pkg::ADDR_W-1:0]   free_addr,
	input  ffa_pkg::cmd_t                cmd,
	output ffa_pkg::sts_t                sts,
	output logic [ffa_pkg::ADDR_W-1:0]   data_addr,
	output logic [ffa_pkg::STAT_W-1:0]   status,
	output logic [$clog2(HEAP_UNITS+1)-1:0] top_units
);
	import ffa_pkg::*;

	localparam int PW    = $clog2(HEAP_UNITS);
	localparam int UW    = $clog2(HEAP_UNITS + 1);
	localparam int HW    = PW + UW + 1;
	// The unit size is a power of two, so the unit count is a shift.
	localparam int UB_SH = $clog2(UNIT_BYTES);

	// Configuration registers.
	logic [ADDR_W-1:0]  base_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [UW-1:0]      top_q;

	// Request and walk registers.
	logic              mode_q;
	logic [REQ_W-1:0]  req_q;
	logic [ADDR_W-1:0] off_q;
	logic [NEED_W-1:0] need_q;
	logic [UW-1:0]     cur_q;
	logic [UW-1:0]     last_q;
	logic [UW-1:0]     tgt_q;
	logic [UW-1:0]     nb_q;
	logic [UW-1:0]     nx_q;
	logic [UW-1:0]     nsize_q;
	logic [UW-1:0]     hsize_q;
	logic [PW-1:0]     hprev_q;
	logic [PW-1:0]     nbprev_q;
	logic              split_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic [STAT_W-1:0] res_stat_q;

	// Header store signals.
	logic          we;
	logic [PW-1:0] waddr;
	logic [HW-1:0] wdata;
	logic [PW-1:0] raddr;
	logic [HW-1:0] rdata;
	logic [PW-1:0] rd_prev;
	logic [UW-1:0] rd_size;
	logic          rd_free;
	logic [UW-1:0]  need_u;

	ffa_ram #(.WIDTH(HW), .DEPTH(HEAP_UNITS)) u_hdr (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd_free = rdata[0];
	assign rd_size = rdata[UW:1];
	assign rd_prev = rdata[HW-1:UW+1];
	assign need_u  = need_q[UW-1:0];

	// Status flags for the controller.
	always_comb begin
		sts.mode       = mode_q;
		sts.req_zero   = (req_q == '0);
		sts.req_big    = ({1'b0, req_q} >= limit_q);
		sts.cur_ge_top = (cur_q >= top_q);
		sts.bs_zero    = (rd_size == '0);
		sts.fit        = rd_free && (32'(rd_size) >= 32'(need_q));
		sts.split      = split_q;
		sts.nx_lt_top  = (nx_q < top_q);
		sts.match      = (off_q == (32'(cur_q) + 32'd1) * 32'(UNIT_BYTES));
		sts.rd_free    = rd_free;
		sts.b_zero     = (cur_q == '0);
		sts.oom        = (32'(top_q) + 32'(need_q)) > 32'(HEAP_UNITS);
	end

	// Header store addressing per operation.
	always_comb begin
		we    = 1'b0;
		waddr = cur_q[PW-1:0];
		wdata = '0;
		raddr = cur_q[PW-1:0];
		unique case (cmd.op)
			OP_TAKE: begin
				we    = (32'(rd_size) != 32'(need_q));
				waddr = PW'(cur_q + need_u);
				wdata = {cur_q[PW-1:0], rd_size - need_u, 1'b1};
			end
			OP_RD_NX: raddr = nx_q[PW-1:0];
			OP_WR_NX: begin
				we    = 1'b1;
				waddr = nx_q[PW-1:0];
				wdata = {nb_q[PW-1:0], rd_size, rd_free};
			end
			OP_WR_TAKE: begin
				we    = 1'b1;
				waddr = tgt_q[PW-1:0];
				wdata = {hprev_q, need_u, 1'b0};
			end
			OP_APPEND: begin
				we    = 1'b1;
				waddr = top_q[PW-1:0];
				wdata = {(top_q == '0) ? '0 : last_q[PW-1:0], need_u, 1'b0};
			end
			OP_RD_P: raddr = hprev_q;
			OP_WR_FREE: begin
				we    = 1'b1;
				waddr = nb_q[PW-1:0];
				wdata = {nbprev_q, nsize_q, 1'b1};
			end
			default: begin
			end
		endcase
	end

	// Configuration and heap top.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			limit_q <= BIG_LIMIT_RST;
			top_q   <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_HEAP_BASE: base_q  <= cfg_data;
					CFG_BIG_LIMIT: limit_q <= cfg_data[LIMIT_W-1:0];
				endcase
			end
			if (cmd.op == OP_APPEND) begin
				top_q <= top_q + need_u;
			end
		end
	end

	// Working registers.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				mode_q <= mode;
				req_q  <= req_size;
				off_q  <= free_addr - base_q;
				cur_q  <= '0;
				last_q <= '0;
			end
			// Header unit plus the request rounded up to whole units.
			OP_NEED: need_q <= NEED_W'(1) +
				((NEED_W'(req_q) + NEED_W'(UNIT_BYTES - 1)) >> UB_SH);
			OP_ADV: begin
				last_q <= cur_q;
				cur_q  <= cur_q + rd_size;
			end
			OP_TAKE: begin
				hprev_q <= rd_prev;
				nb_q    <= cur_q + need_u;
				nx_q    <= cur_q + rd_size;
				split_q <= (32'(rd_size) != 32'(need_q));
				tgt_q   <= cur_q;
			end
			OP_APPEND: tgt_q <= top_q;
			OP_FCAP: begin
				hprev_q  <= rd_prev;
				hsize_q  <= rd_size;
				nb_q     <= cur_q;
				nbprev_q <= rd_prev;
				nsize_q  <= rd_size;
				nx_q     <= cur_q + rd_size;
			end
			OP_MRG_P: begin
				if (rd_free) begin
					nb_q     <= UW'(hprev_q);
					nbprev_q <= rd_prev;
					nsize_q  <= rd_size + hsize_q;
				end
			end
			OP_MRG_N: begin
				if (rd_free) begin
					nsize_q <= nsize_q + rd_size;
					nx_q    <= nx_q + rd_size;
				end
			end
			OP_RESULT: begin
				res_stat_q <= cmd.code;
				if (cmd.code == ST_OK && mode_q == MODE_ALLOC) begin
					res_addr_q <= base_q + (32'(tgt_q) + 32'd1) * 32'(UNIT_BYTES);
				end else begin
					res_addr_q <= '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign data_addr = res_addr_q;
	assign status    = res_stat_q;
	assign top_units = top_q;

endmodule

FILE: design/ffa_ctrl.sv
module ffa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  ffa_pkg::sts_t sts,
	output ffa_pkg::cmd_t cmd
);
	import ffa_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_DECIDE, S_NEED, S_A_RD, S_A_CHK, S_A_SPL, S_A_NXW,
		S_A_WT, S_A_APP, S_F_RD, S_F_CHK, S_F_P, S_F_PC, S_F_N, S_F_NC,
		S_F_X, S_F_XW, S_F_W, S_RES, S_OUT
	} state_t;

	state_t            state_q, state_d;
	logic [STAT_W-1:0] code_q, code_d;

	// Next state and datapath command.
	always_comb begin
		state_d  = state_q;
		code_d   = code_q;
		cmd.op   = OP_IDLE;
		cmd.code = code_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				priority if (sts.mode == MODE_FREE) begin
					state_d = S_F_RD;
				end else if (sts.req_zero) begin
					code_d  = ST_ZERO;
					state_d = S_RES;
				end else if (sts.req_big) begin
					code_d  = ST_BIG;
					state_d = S_RES;
				end else begin
					state_d = S_NEED;
				end
			end
			S_NEED: begin
				cmd.op  = OP_NEED;
				state_d = S_A_RD;
			end
			S_A_RD: begin
				if (sts.cur_ge_top) begin
					state_d = S_A_APP;
				end else begin
					cmd.op  = OP_RD_CUR;
					state_d = S_A_CHK;
				end
			end
			S_A_CHK: begin
				priority if (sts.bs_zero) begin
					state_d = S_A_APP;
				end else if (sts.fit) begin
					cmd.op  = OP_TAKE;
					state_d = S_A_SPL;
				end else begin
					cmd.op  = OP_ADV;
					state_d = S_A_RD;
				end
			end
			S_A_SPL: begin
				if (sts.split && sts.nx_lt_top) begin
					cmd.op  = OP_RD_NX;
					state_d = S_A_NXW;
				end else begin
					state_d = S_A_WT;
				end
			end
			S_A_NXW: begin
				cmd.op  = OP_WR_NX;
				state_d = S_A_WT;
			end
			S_A_WT: begin
				cmd.op  = OP_WR_TAKE;
				code_d  = ST_OK;
				state_d = S_RES;
			end
			S_A_APP: begin
				if (sts.oom) begin
					code_d = ST_OOM;
				end else begin
					cmd.op = OP_APPEND;
					code_d = ST_OK;
				end
				state_d = S_RES;
			end
			S_F_RD: begin
				if (sts.cur_ge_top) begin
					code_d  = ST_IGNORED;
					state_d = S_RES;
				end else begin
					cmd.op  = OP_RD_CUR;
					state_d = S_F_CHK;
				end
			end
			S_F_CHK: begin
				priority if (sts.match) begin
					if (sts.rd_free) begin
						code_d  = ST_IGNORED;
						state_d = S_RES;
					end else begin
						cmd.op  = OP_FCAP;
						state_d = sts.b_zero ? S_F_N : S_F_P;
					end
				end else if (sts.bs_zero) begin
					code_d  = ST_IGNORED;
					state_d = S_RES;
				end else begin
					cmd.op  = OP_ADV;
					state_d = S_F_RD;
				end
			end
			S_F_P: begin
				cmd.op  = OP_RD_P;
				state_d = S_F_PC;
			end
			S_F_PC: begin
				cmd.op  = OP_MRG_P;
				state_d = S_F_N;
			end
			S_F_N: begin
				if (sts.nx_lt_top) begin
					cmd.op  = OP_RD_NX;
					state_d = S_F_NC;
				end else begin
					state_d = S_F_X;
				end
			end
			S_F_NC: begin
				cmd.op  = OP_MRG_N;
				state_d = S_F_X;
			end
			S_F_X: begin
				if (sts.nx_lt_top) begin
					cmd.op  = OP_RD_NX;
					state_d = S_F_XW;
				end else begin
					state_d = S_F_W;
				end
			end
			S_F_XW: begin
				cmd.op  = OP_WR_NX;
				state_d = S_F_W;
			end
			S_F_W: begin
				cmd.op  = OP_WR_FREE;
				code_d  = ST_OK;
				state_d = S_RES;
			end
			S_RES: begin
				cmd.op  = OP_RESULT;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State, result code and the registered output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			code_q    <= ST_OK;
			out_valid <= 1'b0;
		end else begin
			state_q   <= state_d;
			code_q    <= code_d;
			out_valid <= (state_d == S_OUT);
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

FILE: design/first_fit_heap_allocator.sv
// A zero or too large size is rejected; an allocation walks the headers from the heap start
// to the first free block that fits and takes it, splitting off any rest, or else appends a
// block at the heap top; a free walks to the named block and merges it with free neighbours.
// One word at a time: a new word is taken only after the last result is out, which an output
// stall holds back; the header walk over the single-read-port store sets the rate. Reset
// clears the heap top, base and control state and sets the size limit to its default; the
// working registers and header store are left as is; only existing blocks are read from it.
module first_fit_heap_allocator #(
	parameter int HEAP_UNITS = ffa_pkg::HEAP_UNITS_DEF,
	parameter int UNIT_BYTES = ffa_pkg::UNIT_BYTES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [ffa_pkg::ADDR_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       mode,
	input  logic [ffa_pkg::REQ_W-1:0]  req_size,
	input  logic [ffa_pkg::ADDR_W-1:0] free_addr,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [ffa_pkg::ADDR_W-1:0] data_addr,
	output logic [ffa_pkg::STAT_W-1:0] status
);
	import ffa_pkg::*;

	cmd_t                           cmd;
	sts_t                           sts;
	logic [$clog2(HEAP_UNITS+1)-1:0] top_units;

	ffa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ffa_dp #(.HEAP_UNITS(HEAP_UNITS), .UNIT_BYTES(UNIT_BYTES)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mode      (mode),
		.req_size  (req_size),
		.free_addr (free_addr),
		.cmd       (cmd),
		.sts       (sts),
		.data_addr (data_addr),
		.status    (status),
		.top_units (top_units)
	);

	// A failed or ignored request never reports an address.
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> data_addr == '0)
		else $error("nonzero address on a failed request");

	// The heap never grows past its capacity.
	a_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(top_units) <= 32'(HEAP_UNITS))
		else $error("heap top beyond capacity");

	// Once a word is taken, no other is taken until its result is out.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while busy");

	// The heap top only moves while an allocation is in progress.
	a_top_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |=> $stable(top_units))
		else $error("heap top changed while idle");

endmodule
